// ----- rtl/klhp_pkg.sv -----
// Shared types and constants for the keyboard link host protocol block.
// No dependencies.
package klhp_pkg;

   localparam int KEY_ROWS        = 8;
   localparam int ROW_WIDTH       = 3;
   localparam int COL_COUNT       = 16;
   localparam int TIMER_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int RSP_DEPTH       = 4;
   localparam int RSP_PTR_WIDTH   = 2;
   localparam int RSP_CNT_WIDTH   = 3;

   // Link bytes
   localparam logic [7:0] B_RESET    = 8'hFF;
   localparam logic [7:0] B_ACK1     = 8'hFE;
   localparam logic [7:0] B_ACK2     = 8'hFD;
   localparam logic [7:0] B_SCAN     = 8'h33;
   localparam logic [7:0] B_BYTE_ACK = 8'h3F;
   localparam logic [2:0] KEY_PREFIX = 3'b110;   // 0xC0..0xDF
   localparam logic [2:0] MOUSE_ROW  = 3'd7;

   // Configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPLY_TIMEOUT = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RETRY_DELAY   = 1'd1;

   // Event kinds
   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_BYTE = 2'd1;
   localparam logic [1:0] FUNC_LEDS = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_TX    = 2'd0;
   localparam logic [1:0] KIND_MOUSE = 2'd1;
   localparam logic [1:0] KIND_KEY   = 2'd2;

   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_W_RST   = 3'd1,
      PH_W_AK1   = 3'd2,
      PH_W_AK2   = 3'd3,
      PH_BACKOFF = 3'd4,
      PH_SCAN    = 3'd5,
      PH_W_COL   = 3'd6,
      PH_W_MY    = 3'd7
   } phase_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [7:0]        tx_byte;
      logic [2:0]        mouse_buttons;
      logic signed [6:0] mouse_dx;
      logic signed [6:0] mouse_dy;
      logic [2:0]        key_row;
      logic [3:0]        key_col;
      logic              key_pressed;
      logic [15:0]       row_bits;
      logic              last;
   } rsp_type;

endpackage

// ----- rtl/klhp_rsp_fifo.sv -----
// Result queue: takes up to two items per cycle, hands out one per cycle.
// Depends on klhp_pkg.
module klhp_rsp_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        push_count,
   input  klhp_pkg::rsp_type                 push0,
   input  klhp_pkg::rsp_type                 push1,
   input  logic                              pop,
   output klhp_pkg::rsp_type                 head,
   output logic [klhp_pkg::RSP_CNT_WIDTH-1:0] count
);
   import klhp_pkg::*;

   rsp_type                    mem_ff [RSP_DEPTH];
   logic [RSP_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_WIDTH-1:0]   count_ff, count_in;
   logic [RSP_PTR_WIDTH-1:0]   wr_next;

   assign wr_next = wr_ptr_ff + 1'b1;
   assign head    = mem_ff[rd_ptr_ff];
   assign count   = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_WIDTH'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_WIDTH'(push_count) - RSP_CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_next] <= push1;
      end
   end

endmodule

// ----- rtl/keyboard_link_host_protocol.sv -----
// Keyboard link host protocol: handshake, scanning, LED updates.
// Each item is held in the input register, then its results go into the result
// queue, which offers them on the rsp side. One item is taken per cycle while
// the queue has room for two results; results leave one per cycle unless stalled.
// Reset: phase to handshake start, timers, buttons, LEDs and key matrix to
// zero, result queue empty, reply_timeout to 2 and retry_delay to 1000.
module keyboard_link_host_protocol (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_func,
   input  logic [7:0]                          req_rx_byte,
   input  logic [2:0]                          req_host_leds,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_kind,
   output logic [7:0]                          rsp_tx_byte,
   output logic [2:0]                          rsp_mouse_buttons,
   output logic signed [6:0]                   rsp_mouse_dx,
   output logic signed [6:0]                   rsp_mouse_dy,
   output logic [2:0]                          rsp_key_row,
   output logic [3:0]                          rsp_key_col,
   output logic                                rsp_key_pressed,
   output logic [15:0]                         rsp_row_bits,
   output logic                                rsp_last,
   input  logic                                csr_write_enable,
   input  logic [klhp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0]                         csr_write_data
);
   import klhp_pkg::*;

   // Input register
   logic                     in_valid_ff, in_valid_in;
   logic [1:0]               in_func_ff;
   logic [7:0]               in_byte_ff;
   logic [2:0]               in_leds_ff;

   // Configuration
   logic [TIMER_WIDTH-1:0]   reply_timeout_ff, retry_delay_ff;

   // Protocol state
   phase_type                phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0]   wait_timer_ff, wait_timer_in;
   logic [ROW_WIDTH-1:0]     pending_row_ff, pending_row_in;
   logic [6:0]               pending_dx_ff, pending_dx_in;
   logic [2:0]               button_bits_ff, button_bits_in;
   logic [2:0]               led_wanted_ff, led_wanted_in;
   logic [2:0]               led_sent_ff, led_sent_in;
   logic [COL_COUNT-1:0]     key_matrix_ff [KEY_ROWS];
   logic                     mtx_we;
   logic [COL_COUNT-1:0]     mtx_row_in;

   logic                     accept, proc_go, pop;
   logic [1:0]               n_res;
   rsp_type                  res0, res1, head;
   logic [RSP_CNT_WIDTH-1:0] q_count;

   logic                     keyb, mdat, down, is_button;
   logic [3:0]               col;
   logic [COL_COUNT-1:0]     cur_row;

   // Room for two results before an item is processed
   assign proc_go   = in_valid_ff && (q_count <= RSP_CNT_WIDTH'(RSP_DEPTH - 2));
   assign req_stall = in_valid_ff && !proc_go;
   assign accept    = req_valid && !req_stall;
   assign in_valid_in = accept | (in_valid_ff & ~proc_go);

   assign keyb      = in_byte_ff[7:5] == KEY_PREFIX;
   assign mdat      = !in_byte_ff[7];
   assign down      = !in_byte_ff[4];
   assign col       = in_byte_ff[3:0];
   assign cur_row   = key_matrix_ff[pending_row_ff];
   assign is_button = (pending_row_ff == MOUSE_ROW) && (col <= 4'd2);

   function automatic rsp_type tx_res(input logic [7:0] b);
      rsp_type r;
      r         = '0;
      r.kind    = KIND_TX;
      r.tx_byte = b;
      return r;
   endfunction

   always_comb begin
      phase_in       = phase_ff;
      wait_timer_in  = wait_timer_ff;
      pending_row_in = pending_row_ff;
      pending_dx_in  = pending_dx_ff;
      button_bits_in = button_bits_ff;
      led_wanted_in  = led_wanted_ff;
      led_sent_in    = led_sent_ff;
      mtx_we         = 1'b0;
      mtx_row_in     = cur_row;
      n_res          = 2'd0;
      res0           = '0;
      res1           = '0;

      case (in_func_ff)
         FUNC_TICK: begin
            case (phase_ff)
               PH_START: begin
                  n_res         = 2'd1;
                  res0          = tx_res(B_RESET);
                  phase_in      = PH_W_RST;
                  wait_timer_in = reply_timeout_ff;
               end
               PH_W_RST, PH_W_AK1, PH_W_AK2: begin
                  if (wait_timer_ff[TIMER_WIDTH-1:1] == '0) begin
                     phase_in      = PH_BACKOFF;
                     wait_timer_in = retry_delay_ff;
                  end else begin
                     wait_timer_in = wait_timer_ff - 1'b1;
                  end
               end
               PH_BACKOFF: begin
                  if (wait_timer_ff == '0) begin
                     n_res         = 2'd1;
                     res0          = tx_res(B_RESET);
                     phase_in      = PH_W_RST;
                     wait_timer_in = reply_timeout_ff;
                  end else begin
                     wait_timer_in = wait_timer_ff - 1'b1;
                  end
               end
               PH_SCAN: begin
                  if (led_wanted_ff != led_sent_ff) begin
                     n_res       = 2'd1;
                     res0        = tx_res({5'd0, led_wanted_ff});
                     led_sent_in = led_wanted_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         FUNC_BYTE: begin
            case (phase_ff)
               PH_W_RST, PH_W_AK1, PH_W_AK2: begin
                  logic [7:0] expect_b, next_b;
                  phase_type  next_ph;
                  expect_b = B_ACK2;
                  next_b   = B_SCAN;
                  next_ph  = PH_SCAN;
                  if (phase_ff == PH_W_RST) begin
                     expect_b = B_RESET;
                     next_b   = B_ACK1;
                     next_ph  = PH_W_AK1;
                  end else if (phase_ff == PH_W_AK1) begin
                     expect_b = B_ACK1;
                     next_b   = B_ACK2;
                     next_ph  = PH_W_AK2;
                  end
                  if (in_byte_ff != expect_b) begin
                     phase_in      = PH_BACKOFF;
                     wait_timer_in = retry_delay_ff;
                  end else begin
                     n_res         = 2'd1;
                     res0          = tx_res(next_b);
                     phase_in      = next_ph;
                     wait_timer_in = reply_timeout_ff;
                  end
               end
               PH_SCAN: begin
                  if (keyb) begin
                     pending_row_in = in_byte_ff[2:0];
                     n_res          = 2'd1;
                     res0           = tx_res(B_BYTE_ACK);
                     phase_in       = PH_W_COL;
                  end else if (mdat) begin
                     pending_dx_in = in_byte_ff[6:0];
                     n_res         = 2'd1;
                     res0          = tx_res(B_BYTE_ACK);
                     phase_in      = PH_W_MY;
                  end else begin
                     phase_in = PH_START;
                  end
               end
               PH_W_COL: begin
                  if (keyb) begin
                     n_res    = 2'd2;
                     res0     = tx_res(B_SCAN);
                     phase_in = PH_SCAN;
                     if (is_button) begin
                        button_bits_in           = button_bits_ff;
                        button_bits_in[col[1:0]] = down;
                        res1.kind                = KIND_MOUSE;
                        res1.mouse_buttons       = button_bits_in;
                     end else begin
                        mtx_we           = 1'b1;
                        mtx_row_in[col]  = down;
                        res1.kind        = KIND_KEY;
                        res1.key_row     = pending_row_ff;
                        res1.key_col     = col;
                        res1.key_pressed = down;
                        res1.row_bits    = mtx_row_in;
                     end
                  end else begin
                     phase_in = PH_START;
                  end
               end
               PH_W_MY: begin
                  if (mdat) begin
                     n_res              = 2'd2;
                     res0.kind          = KIND_MOUSE;
                     res0.mouse_buttons = button_bits_ff;
                     res0.mouse_dx      = pending_dx_ff;
                     res0.mouse_dy      = in_byte_ff[6:0];
                     res1               = tx_res(B_SCAN);
                     phase_in           = PH_SCAN;
                  end else begin
                     phase_in = PH_START;
                  end
               end
               default: begin
               end
            endcase
         end
         FUNC_LEDS: begin
            // host order is num, caps; link order is caps, num
            led_wanted_in = {in_leds_ff[2], in_leds_ff[0], in_leds_ff[1]};
         end
         default: begin
         end
      endcase

      res0.last = (n_res == 2'd1);
      res1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         reply_timeout_ff <= 16'd2;
         retry_delay_ff   <= 16'd1000;
         phase_ff         <= PH_START;
         wait_timer_ff    <= '0;
         pending_row_ff   <= '0;
         pending_dx_ff    <= '0;
         button_bits_ff   <= '0;
         led_wanted_ff    <= '0;
         led_sent_ff      <= '0;
         key_matrix_ff    <= '{default: '0};
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_REPLY_TIMEOUT: reply_timeout_ff <= csr_write_data;
               CSR_RETRY_DELAY:   retry_delay_ff   <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (proc_go) begin
            phase_ff       <= phase_in;
            wait_timer_ff  <= wait_timer_in;
            pending_row_ff <= pending_row_in;
            pending_dx_ff  <= pending_dx_in;
            button_bits_ff <= button_bits_in;
            led_wanted_ff  <= led_wanted_in;
            led_sent_ff    <= led_sent_in;
            if (mtx_we) begin
               key_matrix_ff[pending_row_ff] <= mtx_row_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_func_ff <= req_func;
         in_byte_ff <= req_rx_byte;
         in_leds_ff <= req_host_leds;
      end
   end

   assign rsp_valid = q_count != '0;
   assign pop       = rsp_valid && !rsp_stall;

   klhp_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (proc_go ? n_res : 2'd0),
      .push0      (res0),
      .push1      (res1),
      .pop        (pop),
      .head       (head),
      .count      (q_count)
   );

   assign rsp_kind          = head.kind;
   assign rsp_tx_byte       = head.tx_byte;
   assign rsp_mouse_buttons = head.mouse_buttons;
   assign rsp_mouse_dx      = head.mouse_dx;
   assign rsp_mouse_dy      = head.mouse_dy;
   assign rsp_key_row       = head.key_row;
   assign rsp_key_col       = head.key_col;
   assign rsp_key_pressed   = head.key_pressed;
   assign rsp_row_bits      = head.row_bits;
   assign rsp_last          = head.last;

endmodule
